/* src/cdd_pkg.sv */
// Shared types and constants for the CAN datagram deframer.
package cdd_pkg;

   // Number of peers with sequence tracking (default for the top-level parameter).
   localparam int PEER_COUNT_DEFAULT = 8;

   // Largest data length a frame record may carry.
   localparam int MAX_DATA_BYTES = 8;

   // Widths of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_OPCODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIDGE_MODE  = 2'd2;

   // Register reset values.
   localparam logic [7:0] VERSION_CODE_RESET = 8'd2;
   localparam logic [7:0] DATA_OPCODE_RESET  = 8'd0;
   localparam logic       BRIDGE_MODE_RESET  = 1'b1;

   // Parser position within a datagram.
   typedef enum logic [3:0] {
      PH_HDR0   = 4'd0,
      PH_HDR1   = 4'd1,
      PH_HDR2   = 4'd2,
      PH_HDR3   = 4'd3,
      PH_HDR4   = 4'd4,
      PH_ID0    = 4'd5,
      PH_ID1    = 4'd6,
      PH_ID2    = 4'd7,
      PH_ID3    = 4'd8,
      PH_LEN    = 4'd9,
      PH_DATA   = 4'd10,
      PH_IGNORE = 4'd11
   } phase_type;

   // Result kinds.
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_LOST  = 1'b1;

endpackage

/* src/can_datagram_deframer_core.sv */
// Datagram deframer: header check, per-peer sequence tracking and frame record parsing.
// A result reaches rsp_* through the input register and then the result register.
// Throughput: one byte per cycle unless a finished result waits under rsp_stall;
//   while it waits, a byte still enters the input register if that register is empty.
// Reset (synchronous, active high): parser returns to header byte zero, all peer
//   sequence valid bits clear, registers take their reset values; no clearing pass.
module can_datagram_deframer_core
   import cdd_pkg::*;
#(
   parameter int PEER_COUNT = PEER_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   input  logic [2:0]             req_peer_index,
   input  logic                   req_link_up,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [28:0]            rsp_identifier,
   output logic                   rsp_extended,
   output logic                   rsp_remote,
   output logic [3:0]             rsp_length,
   output logic [63:0]            rsp_payload,
   output logic [6:0]             rsp_lost_count,
   output logic                   rsp_transmit,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PIDX_W = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
   // ---------------------------------------------------------------------
   logic [7:0] version_ff;
   logic [7:0] opcode_ff;
   logic       bridge_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_CODE_RESET;
         opcode_ff  <= DATA_OPCODE_RESET;
         bridge_ff  <= BRIDGE_MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERSION_CODE: version_ff <= csr_data;
            CSR_DATA_OPCODE:  opcode_ff  <= csr_data;
            CSR_BRIDGE_MODE:  bridge_ff  <= csr_data[0];
            default:          ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. The byte in it is processed (advance) whenever the
   // result register is free or drains this cycle.
   // ---------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic [2:0] in_peer_ff;
   logic       in_link_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
         in_peer_ff <= req_peer_index;
         in_link_ff <= req_link_up;
      end
   end

   // ---------------------------------------------------------------------
   // Parser state.
   // ---------------------------------------------------------------------
   phase_type        phase_ff, phase_in;
   logic [2:0]       peer_ff, peer_in;
   logic [7:0]       hdr_seq_ff, hdr_seq_in;
   logic [15:0]      frames_ff, frames_in;
   logic [31:0]      id_ff, id_in;
   logic [3:0]       len_ff, len_in;
   logic [63:0]      data_ff, data_in;
   logic [3:0]       pos_ff, pos_in;

   // Per-peer sequence state: valid bits in flops, last sequence in a memory.
   logic [PEER_COUNT-1:0] seq_valid_ff;
   logic [7:0]            seq_mem [PEER_COUNT];
   logic [7:0]            seq_rd_ff;
   logic [PIDX_W-1:0]     seq_rd_addr;
   logic [PIDX_W-1:0]     seq_wr_addr;
   logic                  seq_we;

   // Work signals.
   phase_type   work_phase;
   logic        peer_unknown;
   logic        emit;
   logic        report;
   logic [7:0]  gap;
   logic [15:0] frames_dec;
   logic [3:0]  pos_next;
   logic        frame_rtr;
   logic        frame_ext;

   assign peer_unknown = (32'(in_peer_ff) >= PEER_COUNT);
   assign frame_ext    = id_ff[31];
   assign frame_rtr    = id_ff[30];
   assign frames_dec   = frames_ff - 16'd1;
   assign pos_next     = pos_ff + 4'd1;
   assign gap          = hdr_seq_ff - (seq_rd_ff + 8'd1);
   assign seq_wr_addr  = PIDX_W'(peer_ff);
   assign seq_rd_addr  = PIDX_W'(peer_in);

   always_comb begin
      phase_in   = phase_ff;
      peer_in    = peer_ff;
      hdr_seq_in = hdr_seq_ff;
      frames_in  = frames_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      data_in    = data_ff;
      pos_in     = pos_ff;
      emit       = 1'b0;
      report     = 1'b0;
      seq_we     = 1'b0;
      work_phase = phase_ff;

      if (advance) begin
         // Latch the sender on the first byte; drop datagrams from unknown peers.
         if (phase_ff == PH_HDR0) begin
            peer_in = in_peer_ff;
            if (peer_unknown) begin
               work_phase = PH_IGNORE;
            end
         end
         phase_in = work_phase;

         unique case (work_phase)
            PH_HDR0: begin
               phase_in = (in_byte_ff == version_ff) ? PH_HDR1 : PH_IGNORE;
            end
            PH_HDR1: begin
               phase_in = (in_byte_ff == opcode_ff) ? PH_HDR2 : PH_IGNORE;
            end
            PH_HDR2: begin
               hdr_seq_in = in_byte_ff;
               phase_in   = PH_HDR3;
            end
            PH_HDR3: begin
               frames_in = {in_byte_ff, 8'd0};
               phase_in  = PH_HDR4;
            end
            PH_HDR4: begin
               frames_in = {frames_ff[15:8], in_byte_ff};
               seq_we    = 1'b1;
               // Forward gap of 1..127 is a loss; larger gaps mean a restart.
               report    = seq_valid_ff[seq_wr_addr] && (gap != 8'd0) && !gap[7];
               if (frames_in == 16'd0) begin
                  phase_in = PH_IGNORE;
               end else begin
                  phase_in = PH_ID0;
                  id_in    = 32'd0;
               end
            end
            PH_ID0, PH_ID1, PH_ID2, PH_ID3: begin
               id_in    = {id_ff[23:0], in_byte_ff};
               phase_in = phase_type'(work_phase + 4'd1);
            end
            PH_LEN: begin
               if (in_byte_ff > 8'(MAX_DATA_BYTES)) begin
                  phase_in = PH_IGNORE;
               end else begin
                  len_in  = in_byte_ff[3:0];
                  data_in = 64'd0;
                  pos_in  = 4'd0;
                  if (frame_rtr || in_byte_ff == 8'd0) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                  if (pos_ff[2:0] == 3'(i)) begin
                     data_in[8*i +: 8] = in_byte_ff;
                  end
               end
               pos_in = pos_next;
               if (pos_next >= len_ff) begin
                  emit = 1'b1;
               end
            end
            PH_IGNORE: begin
               phase_in = PH_IGNORE;
            end
            default: begin
               phase_in = PH_IGNORE;
            end
         endcase

         // Frame complete: move to the next record or ignore the rest.
         if (emit) begin
            frames_in = frames_dec;
            if (frames_dec == 16'd0) begin
               phase_in = PH_IGNORE;
            end else begin
               phase_in = PH_ID0;
               id_in    = 32'd0;
            end
         end

         // Restart at header byte zero after the final byte of a datagram.
         if (in_last_ff) begin
            phase_in = PH_HDR0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         peer_ff      <= 3'd0;
         hdr_seq_ff   <= 8'd0;
         frames_ff    <= 16'd0;
         id_ff        <= 32'd0;
         len_ff       <= 4'd0;
         data_ff      <= 64'd0;
         pos_ff       <= 4'd0;
         seq_valid_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         peer_ff    <= peer_in;
         hdr_seq_ff <= hdr_seq_in;
         frames_ff  <= frames_in;
         id_ff      <= id_in;
         len_ff     <= len_in;
         data_ff    <= data_in;
         pos_ff     <= pos_in;
         if (seq_we) begin
            seq_valid_ff[seq_wr_addr] <= 1'b1;
         end
      end
   end

   // Sequence memory: the read tracks the next peer so the data is ready by
   // header byte four; no write lands between that read and its use.
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_wr_addr] <= hdr_seq_ff;
      end
      if (advance) begin
         seq_rd_ff <= seq_mem[seq_rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Result register. Hold while stalled, load on a producing byte.
   // ---------------------------------------------------------------------
   logic        rsp_valid_in;
   logic        rsp_kind_ff;
   logic [28:0] rsp_ident_ff;
   logic        rsp_ext_ff;
   logic        rsp_rtr_ff;
   logic [3:0]  rsp_len_ff;
   logic [63:0] rsp_payload_ff;
   logic [6:0]  rsp_lost_ff;
   logic        rsp_tx_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = emit || report;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && report) begin
         rsp_kind_ff    <= KIND_LOST;
         rsp_ident_ff   <= 29'd0;
         rsp_ext_ff     <= 1'b0;
         rsp_rtr_ff     <= 1'b0;
         rsp_len_ff     <= 4'd0;
         rsp_payload_ff <= 64'd0;
         rsp_lost_ff    <= gap[6:0];
         rsp_tx_ff      <= 1'b0;
      end else if (advance && emit) begin
         rsp_kind_ff    <= KIND_FRAME;
         rsp_ident_ff   <= frame_ext ? id_ff[28:0] : {18'd0, id_ff[10:0]};
         rsp_ext_ff     <= frame_ext;
         rsp_rtr_ff     <= frame_rtr;
         rsp_len_ff     <= len_in;
         rsp_payload_ff <= frame_rtr ? 64'd0 : data_in;
         rsp_lost_ff    <= 7'd0;
         rsp_tx_ff      <= bridge_ff && in_link_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_identifier = rsp_ident_ff;
   assign rsp_extended   = rsp_ext_ff;
   assign rsp_remote     = rsp_rtr_ff;
   assign rsp_length     = rsp_len_ff;
   assign rsp_payload    = rsp_payload_ff;
   assign rsp_lost_count = rsp_lost_ff;
   assign rsp_transmit   = rsp_tx_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_lost_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LOST |->
         rsp_identifier == 29'd0 && rsp_length == 4'd0 && !rsp_transmit &&
         rsp_payload == 64'd0 && rsp_lost_count != 7'd0)
      else $error("lost report carries frame fields");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FRAME |->
         rsp_lost_count == 7'd0 && rsp_length <= 4'(MAX_DATA_BYTES))
      else $error("frame result out of range");

   a_data_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> len_ff != 4'd0 && pos_ff < len_ff)
      else $error("data phase with bad length or position");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> phase_ff == PH_HDR0)
      else $error("parser did not restart after final byte");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without back-pressure");

endmodule
